@@ rtl/core/adaptive_block_scan_select_top_defines.svh @@
// assertion macros for the adaptive block scan selector
// used by the datapath; expects clk and rst_n in the including module
`ifndef ADAPTIVE_BLOCK_SCAN_SELECT_TOP_DEFINES_SVH
`define ADAPTIVE_BLOCK_SCAN_SELECT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ABSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ABSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABSS_ASSERT_IMP(label, ante, cons, msg)
`define ABSS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/abss_pkg.sv @@
// shared types, constants and helper functions for the block scan selector
// no dependencies
`default_nettype none

package abss_pkg;

    // block geometry
    localparam int SIDE_BITS  = 4;
    localparam int BLOCK_SIDE = 1 << SIDE_BITS;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int PIXELS     = BLOCK_SIDE * BLOCK_SIDE;
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int PIXEL_BITS = 8;
    localparam int COST_BITS  = 16;

    localparam logic [CNT_BITS-1:0]  PIXELS_CNT = CNT_BITS'(PIXELS);
    localparam logic [CNT_BITS-1:0]  LAST_CNT   = CNT_BITS'(PIXELS - 1);
    localparam logic [COST_BITS-1:0] COST_MAX   = '1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // scan modes
    localparam logic MODE_HORIZ = 1'b0;
    localparam logic MODE_VERT  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_in;
    } in_beat_t;

    typedef struct packed {
        logic        is_header;
        logic        scan_mode;
        logic [15:0] horizontal_cost;
        logic [15:0] vertical_cost;
        logic [7:0]  pixel_out;
        logic        last;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic read_en;
        logic sweep_step;
        logic hdr_emit;
        logic pix_emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic load_last;
        logic block_full;
        logic read_done;
        logic sweep_done;
        logic out_free;
    } status_t;

    function automatic logic [PIXEL_BITS-1:0] abs_diff(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [COST_BITS-1:0] sat_add(
        input logic [COST_BITS-1:0]  acc,
        input logic [PIXEL_BITS-1:0] d
    );
        logic [COST_BITS:0] s;
        s = {1'b0, acc} + {{(COST_BITS + 1 - PIXEL_BITS){1'b0}}, d};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction

    // raster position of the r-th pixel in column-major order
    function automatic logic [ADDR_BITS-1:0] col_major(input logic [ADDR_BITS-1:0] r);
        return {r[SIDE_BITS-1:0], r[ADDR_BITS-1:SIDE_BITS]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/abss_ctrl.sv @@
// controller state machine for the block scan selector
// depends on abss_pkg
`default_nettype none

module abss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_kind,
    output logic                   item_stall,
    input  wire abss_pkg::status_t status,
    output abss_pkg::cmd_t         cmd
);
    import abss_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // take a beat only when idle and the result register can be refilled
    assign item_stall = !((state_reg == ST_IDLE) && status.out_free);
    assign accept     = item_valid && !item_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_kind == KIND_LOAD)
                    begin
                        cmd.load_en = 1'b1;
                        if (status.load_last)
                        begin
                            state_next = ST_SWEEP;
                        end
                    end
                    else if (item_kind == KIND_READ && status.block_full &&
                             !status.read_done)
                    begin
                        cmd.read_en = 1'b1;
                        state_next  = ST_READ_OUT;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                begin
                    cmd.hdr_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ_OUT:
            begin
                cmd.pix_emit = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/abss_dp.sv @@
// datapath for the block scan selector: pixel store, cost accumulators, result register
// depends on abss_pkg and adaptive_block_scan_select_top_defines.svh
`default_nettype none
`include "adaptive_block_scan_select_top_defines.svh"

module abss_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire abss_pkg::in_beat_t item,
    input  wire abss_pkg::cmd_t     cmd,
    output abss_pkg::status_t       status,
    input  wire logic               result_stall,
    output logic                    result_valid,
    output abss_pkg::out_beat_t     result
);
    import abss_pkg::*;

    logic [PIXEL_BITS-1:0] mem [PIXELS];

    logic [CNT_BITS-1:0]   load_cnt_reg,  load_cnt_next;
    logic [CNT_BITS-1:0]   read_cnt_reg,  read_cnt_next;
    logic [COST_BITS-1:0]  hacc_reg,      hacc_next;
    logic [PIXEL_BITS-1:0] hprev_reg,     hprev_next;
    logic [COST_BITS-1:0]  vacc_reg,      vacc_next;
    logic [PIXEL_BITS-1:0] vprev_reg,     vprev_next;
    logic [CNT_BITS-1:0]   sweep_idx_reg, sweep_idx_next;
    logic                  sweep_vld_reg, sweep_vld_next;
    logic                  mode_reg,      mode_next;
    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_reg,       out_next;
    logic [PIXEL_BITS-1:0] rd_data_reg;

    logic                  restart;
    logic [PIXEL_BITS-1:0] pix;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  read_pos;
    logic                  mem_re;
    logic                  hdr_mode;

    assign pix     = item.pixel_in[PIXEL_BITS-1:0];
    assign restart = (load_cnt_reg == PIXELS_CNT);
    assign wr_addr = restart ? '0 : load_cnt_reg[ADDR_BITS-1:0];

    // read port address: column sweep, or readout in the chosen order
    assign read_pos = (mode_reg == MODE_VERT) ? col_major(read_cnt_reg[ADDR_BITS-1:0])
                                              : read_cnt_reg[ADDR_BITS-1:0];
    assign rd_addr  = cmd.sweep_step ? col_major(sweep_idx_reg[ADDR_BITS-1:0]) : read_pos;
    assign mem_re   = cmd.read_en || (cmd.sweep_step && !sweep_idx_reg[CNT_BITS-1]);

    // pixel store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            mem[wr_addr] <= pix;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign hdr_mode = (vacc_reg < hacc_reg) ? MODE_VERT : MODE_HORIZ;

    // counters, accumulators and result register next values
    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        read_cnt_next  = read_cnt_reg;
        hacc_next      = hacc_reg;
        hprev_next     = hprev_reg;
        vacc_next      = vacc_reg;
        vprev_next     = vprev_reg;
        sweep_idx_next = sweep_idx_reg;
        sweep_vld_next = sweep_vld_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        // load beat: row-major cost, new block after a complete one
        if (cmd.load_en)
        begin
            hacc_next      = sat_add(restart ? '0 : hacc_reg,
                                     abs_diff(restart ? '0 : hprev_reg, pix));
            hprev_next     = pix;
            load_cnt_next  = restart ? CNT_BITS'(1) : load_cnt_reg + 1'b1;
            read_cnt_next  = restart ? '0 : read_cnt_reg;
            vacc_next      = '0;
            vprev_next     = '0;
            sweep_idx_next = '0;
            sweep_vld_next = 1'b0;
        end

        // column-major sweep: read one pixel, accumulate the one read before
        if (cmd.sweep_step)
        begin
            if (!sweep_idx_reg[CNT_BITS-1])
            begin
                sweep_idx_next = sweep_idx_reg + 1'b1;
            end
            sweep_vld_next = !sweep_idx_reg[CNT_BITS-1];
            if (sweep_vld_reg)
            begin
                vacc_next  = sat_add(vacc_reg, abs_diff(vprev_reg, rd_data_reg));
                vprev_next = rd_data_reg;
            end
        end

        // readout beat advances the read position
        if (cmd.read_en)
        begin
            read_cnt_next = read_cnt_reg + 1'b1;
        end

        // header beat
        if (cmd.hdr_emit)
        begin
            mode_next                = hdr_mode;
            out_valid_next           = 1'b1;
            out_next.is_header       = 1'b1;
            out_next.scan_mode       = hdr_mode;
            out_next.horizontal_cost = hacc_reg;
            out_next.vertical_cost   = vacc_reg;
            out_next.pixel_out       = '0;
            out_next.last            = 1'b0;
        end

        // pixel beat
        if (cmd.pix_emit)
        begin
            out_valid_next           = 1'b1;
            out_next.is_header       = 1'b0;
            out_next.scan_mode       = mode_reg;
            out_next.horizontal_cost = '0;
            out_next.vertical_cost   = '0;
            out_next.pixel_out       = 8'(rd_data_reg);
            out_next.last            = (read_cnt_reg == PIXELS_CNT);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            hacc_reg      <= '0;
            hprev_reg     <= '0;
            vacc_reg      <= '0;
            vprev_reg     <= '0;
            sweep_idx_reg <= '0;
            sweep_vld_reg <= 1'b0;
            mode_reg      <= MODE_HORIZ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg  <= load_cnt_next;
            read_cnt_reg  <= read_cnt_next;
            hacc_reg      <= hacc_next;
            hprev_reg     <= hprev_next;
            vacc_reg      <= vacc_next;
            vprev_reg     <= vprev_next;
            sweep_idx_reg <= sweep_idx_next;
            sweep_vld_reg <= sweep_vld_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // status back to the controller
    always_comb
    begin
        status.load_last  = (load_cnt_reg == LAST_CNT);
        status.block_full = (load_cnt_reg == PIXELS_CNT);
        status.read_done  = (read_cnt_reg == PIXELS_CNT);
        status.sweep_done = sweep_idx_reg[CNT_BITS-1] && !sweep_vld_reg;
        status.out_free   = !out_valid_reg || !result_stall;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ABSS_ASSERT_IMP(a_load_cnt_range, 1'b1, load_cnt_reg <= PIXELS_CNT, "load count past block")
    `ABSS_ASSERT_IMP(a_read_legal, cmd.read_en, status.block_full && !status.read_done, "bad read")
    `ABSS_ASSERT_IMP(a_hdr_after_sweep, cmd.hdr_emit, status.sweep_done, "early header")
    `ABSS_ASSERT_IMP(a_no_overwrite, cmd.hdr_emit || cmd.pix_emit, status.out_free, "beat lost")
    `ABSS_ASSERT_NXT(a_emit_valid, cmd.hdr_emit || cmd.pix_emit, out_valid_reg, "no result beat")

endmodule

`default_nettype wire

@@ rtl/core/adaptive_block_scan_select_top.sv @@
// Adaptive block scan selector, top level.
// Item channel (item_valid/item_stall/item) carries load and read beats; result
// channel (result_valid/result_stall/result) carries header and pixel beats.
// A beat moves at a rising edge with valid high and stall low.
// Loads store one 16x16 block in raster order, one beat per cycle, and keep the
// row-major cost on the fly. The last load starts a column-major sweep of the
// pixel store, one read per cycle through its single read port; the header beat
// follows the end of the sweep, and item_stall stays high meanwhile.
// Each read beat gives its pixel through the registered store read and then the
// result register; a new read is taken only once the last has left the read-out
// state. Loads and reads that give no result do not leave the idle state.
// A load after a complete block starts a new block. Reset clears counters, costs
// and mode; the pixel store holds nothing until loaded.
// While a result beat waits under result_stall it holds, and no new item is taken.
// depends on abss_pkg, abss_ctrl, abss_dp
`default_nettype none

module adaptive_block_scan_select_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire abss_pkg::in_beat_t item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output abss_pkg::out_beat_t     result
);
    import abss_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    abss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // store, costs and result register
    abss_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
